[src/wve_pkg.sv]
// Package for the windowed velocity estimator.
// Holds the default sizes, fixed field widths, sequencer states and the saturation helper.
// No dependencies.
package wve_pkg;

  localparam int HISTORY_DEPTH_DEF   = 64;
  localparam int ROBOTS_PER_TEAM_DEF = 16;

  localparam logic [31:0] WINDOW_RESET = 32'd500000;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic signed [16:0] HEADING_PI     = 17'sd12868;
  localparam logic signed [16:0] HEADING_TWO_PI = 17'sd25736;

  localparam int DIVIDEND_W = 37;  // 16-bit magnitude times 1e6 plus half span
  localparam int SPAN_W     = 32;
  localparam int VEL_W      = 24;
  localparam int LANES      = 3;

  localparam logic [1:0] GROUP_BALL = 2'd2;
  localparam logic [1:0] GROUP_NONE = 2'd3;
  localparam logic       MODE_APPEND = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_META, S_LOAD, S_PRUNE_RD, S_PRUNE_CHK, S_FIN,
    S_RD_NEW, S_CALC, S_MUL, S_DIV, S_DONE
  } wve_state_t;

  // sign and saturate a rounded quotient to 24-bit signed
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic neg,
                                                      input logic [DIVIDEND_W-1:0] q);
    logic [DIVIDEND_W-1:0] lim_pos;
    lim_pos = DIVIDEND_W'(2**(VEL_W-1) - 1);
    if (!neg) begin
      sat_vel = (q > lim_pos) ? {1'b0, {(VEL_W-1){1'b1}}} : VEL_W'(q);
    end else begin
      sat_vel = (q > lim_pos + 1'b1) ? {1'b1, {(VEL_W-1){1'b0}}} : VEL_W'(-q);
    end
  endfunction

endpackage

[src/wve_div.sv]
// Bit-serial restoring divider with parallel lanes sharing one divisor.
// Uses wve_pkg for widths; one quotient bit per lane per cycle.
module wve_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [wve_pkg::DIVIDEND_W-1:0] dividend [wve_pkg::LANES],
  input  logic [wve_pkg::SPAN_W-1:0] divisor,
  output logic done,
  output logic [wve_pkg::DIVIDEND_W-1:0] quotient [wve_pkg::LANES]
);
  import wve_pkg::*;

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [SPAN_W-1:0]     rem_r [LANES];
  logic [DIVIDEND_W-1:0] quo_r [LANES];
  logic [SPAN_W-1:0]     dvs_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r, done_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    logic [SPAN_W:0] trial;
    for (int i = 0; i < LANES; i++) begin
      if (start) begin
        rem_r[i] <= '0;
        quo_r[i] <= dividend[i];
      end else if (busy_r) begin
        trial = {rem_r[i], quo_r[i][DIVIDEND_W-1]};
        if (trial >= {1'b0, dvs_r}) begin
          rem_r[i] <= SPAN_W'(trial - {1'b0, dvs_r});
          quo_r[i] <= {quo_r[i][DIVIDEND_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= SPAN_W'(trial);
          quo_r[i] <= {quo_r[i][DIVIDEND_W-2:0], 1'b0};
        end
      end
    end
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/windowed_velocity_estimator.sv]
// Top level of the windowed velocity estimator.
// Uses wve_pkg and the bit-serial divider wve_div.
//
// Usage:
//   Input channel (in_*): one item per pose sample (mode 0) or query (mode 1)
//   for an own robot, opponent robot or the ball. Result channel (out_*):
//   exactly one result item per input item, in order. Config channel (cfg_*):
//   writes the window length in microseconds; always ready, write only while idle.
// Sequencing:
//   One item is worked at a time. An item runs through the meta read, the load,
//   a pruning walk that drops stale entries one by one on the single history
//   read port (a read state and a check state per entry), then the bit-serial
//   divider (one quotient bit per cycle, three lanes for x, y and heading).
//   A bad object goes straight from idle to done with a zero result.
// Reset:
//   rst_n is synchronous, active low. All histories become empty (valid bits on
//   the per-object pointer table), the latest robot time clears and the window
//   returns to 500000 us. The history memory itself is not cleared.
// Stall:
//   The result sits in an output register; a new item is taken while it waits,
//   and the sequencer holds its next result until the register frees up.
module windowed_velocity_estimator #(
  parameter int HISTORY_DEPTH   = wve_pkg::HISTORY_DEPTH_DEF,
  parameter int ROBOTS_PER_TEAM = wve_pkg::ROBOTS_PER_TEAM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [1:0]  in_object_group,
  input  logic [3:0]  in_robot_index,
  input  logic [31:0] in_sample_time,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [14:0] in_heading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_velocity_valid,
  output logic signed [23:0] out_vel_x,
  output logic signed [23:0] out_vel_y,
  output logic signed [23:0] out_vel_heading,
  output logic [6:0]  out_entries_held,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_window_length
);
  import wve_pkg::*;

  localparam int NUM_OBJECTS = 2 * ROBOTS_PER_TEAM + 1;
  localparam int OW     = $clog2(NUM_OBJECTS);
  localparam int MEM_N  = NUM_OBJECTS * HISTORY_DEPTH;
  localparam int AW     = $clog2(MEM_N);
  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SW     = PTR_W + 2;
  localparam int META_W = PTR_W + CNT_W;
  localparam int ENT_W  = 80;  // time, heading, y, x

  wve_state_t state_r, state_nxt;

  // config
  logic [31:0] window_r;
  always_ff @(posedge clk) begin
    if (!rst_n) window_r <= WINDOW_RESET;
    else if (cfg_valid && cfg_ready) window_r <= cfg_window_length;
  end
  assign cfg_ready = 1'b1;

  // item fields
  logic        mode_r, ball_r;
  logic [31:0] time_r, now_r, latest_r;
  logic [15:0] x_r, y_r, h_r;
  logic [OW-1:0] obj_r;
  logic [AW-1:0] base_r;
  logic [PTR_W-1:0] ptr_r;
  logic [CNT_W-1:0] cnt_r;

  logic in_acc, bad_obj;
  logic [OW-1:0] obj_in;
  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign bad_obj  = (in_object_group == GROUP_NONE) ||
                    (in_object_group != GROUP_BALL &&
                     32'(in_robot_index) >= 32'(ROBOTS_PER_TEAM));
  assign obj_in   = (in_object_group == GROUP_BALL) ? OW'(2 * ROBOTS_PER_TEAM) :
                    OW'(32'(in_object_group) * 32'(ROBOTS_PER_TEAM) + 32'(in_robot_index));

  // per-object pointer/count table with valid bits
  logic [META_W-1:0]      meta_mem [NUM_OBJECTS];
  logic [NUM_OBJECTS-1:0] meta_vld_r;
  logic [META_W-1:0]      meta_rd_r;
  logic                   meta_rd_vld_r;
  logic                   meta_we;
  always_ff @(posedge clk) begin
    meta_rd_r <= meta_mem[obj_r];
    if (meta_we) meta_mem[obj_r] <= {ptr_r, cnt_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r    <= '0;
      meta_rd_vld_r <= 1'b0;
    end else begin
      meta_rd_vld_r <= meta_vld_r[obj_r];
      if (meta_we) meta_vld_r[obj_r] <= 1'b1;
    end
  end

  // history memory
  logic [ENT_W-1:0] hist_mem [MEM_N];
  logic [ENT_W-1:0] hist_rd_r;
  logic [AW-1:0]    hist_raddr, hist_waddr;
  logic             hist_we;
  always_ff @(posedge clk) begin
    hist_rd_r <= hist_mem[hist_raddr];
    if (hist_we) hist_mem[hist_waddr] <= {time_r, h_r, y_r, x_r};
  end

  // pointer arithmetic on loaded meta
  logic [PTR_W-1:0] ld_ptr, app_slot, ptr_inc, new_slot;
  logic [CNT_W-1:0] ld_cnt;
  logic [SW-1:0]    ssum, nsum;
  logic             ld_full;
  assign ld_ptr  = meta_rd_vld_r ? meta_rd_r[META_W-1:CNT_W] : '0;
  assign ld_cnt  = meta_rd_vld_r ? meta_rd_r[CNT_W-1:0] : '0;
  assign ld_full = 32'(ld_cnt) >= 32'(HISTORY_DEPTH);
  assign ssum    = SW'(ld_ptr) + SW'(ld_cnt);
  assign app_slot = (ssum >= SW'(HISTORY_DEPTH)) ? PTR_W'(ssum - SW'(HISTORY_DEPTH)) :
                                                  PTR_W'(ssum);
  assign nsum    = SW'(ptr_r) + SW'(cnt_r) - SW'(1);
  assign new_slot = (nsum >= SW'(HISTORY_DEPTH)) ? PTR_W'(nsum - SW'(HISTORY_DEPTH)) :
                                                  PTR_W'(nsum);
  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (32'(p) == HISTORY_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction
  assign ptr_inc = wrap_inc(ptr_r);

  // pruning test
  logic [31:0] ts_old;
  logic        drop;
  assign ts_old = hist_rd_r[79:48];
  assign drop   = (now_r > ts_old) && ((now_r - ts_old) > window_r);

  // velocity datapath
  logic [ENT_W-1:0] old_r;
  logic [31:0]      dt_r;
  logic [15:0]      mag_r [LANES];
  logic [LANES-1:0] neg_r;
  logic [DIVIDEND_W-1:0] dvd [LANES];
  logic [DIVIDEND_W-1:0] quo [LANES];
  logic             div_start, div_done;

  logic signed [16:0] dx, dy, dh, dhw;
  assign dx = 17'($signed(hist_rd_r[15:0]))  - 17'($signed(old_r[15:0]));
  assign dy = 17'($signed(hist_rd_r[31:16])) - 17'($signed(old_r[31:16]));
  assign dh = 17'($signed(hist_rd_r[47:32])) - 17'($signed(old_r[47:32]));
  // heading difference needs at most one wrap step
  assign dhw = (dh >= HEADING_PI) ? dh - HEADING_TWO_PI :
               (dh < -HEADING_PI) ? dh + HEADING_TWO_PI : dh;

  function automatic logic [15:0] mag16(input logic signed [16:0] v);
    logic signed [16:0] a;
    a = v[16] ? -v : v;
    mag16 = a[15:0];
  endfunction

  // rounded dividends: magnitude times 1e6 plus half the span
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dvd[i] = DIVIDEND_W'(mag_r[i]) * DIVIDEND_W'(USEC_PER_SEC) +
               DIVIDEND_W'(dt_r >> 1);
    end
  end

  wve_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quo)
  );

  // result staging and output register
  logic        res_vld_r;
  logic signed [VEL_W-1:0] res_x_r, res_y_r, res_h_r;
  logic [6:0]  res_ent_r;
  logic        out_valid_r, out_free;
  assign out_free = !out_valid_r || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and memory controls
  always_comb begin
    state_nxt  = state_r;
    hist_raddr = base_r + AW'(ptr_r);
    hist_waddr = base_r + AW'(app_slot);
    hist_we    = 1'b0;
    meta_we    = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE:      if (in_acc) state_nxt = bad_obj ? S_DONE : S_META;
      S_META:      state_nxt = S_LOAD;
      S_LOAD: begin
        hist_we   = (mode_r == MODE_APPEND);
        if (ld_full) hist_waddr = base_r + AW'(ld_ptr);
        state_nxt = S_PRUNE_RD;
      end
      S_PRUNE_RD:  state_nxt = (cnt_r == '0) ? S_FIN : S_PRUNE_CHK;
      S_PRUNE_CHK: state_nxt = drop ? S_PRUNE_RD : S_FIN;
      S_FIN: begin
        meta_we   = 1'b1;
        state_nxt = (32'(cnt_r) >= 2) ? S_RD_NEW : S_DONE;
      end
      S_RD_NEW: begin
        hist_raddr = base_r + AW'(new_slot);
        state_nxt  = S_CALC;
      end
      S_CALC: state_nxt = (hist_rd_r[79:48] > old_r[79:48]) ? S_MUL : S_DONE;
      S_MUL: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV:  if (div_done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // item working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_r <= '0;
    end else if (state_r == S_LOAD && mode_r == MODE_APPEND && !ball_r) begin
      latest_r <= time_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        mode_r    <= in_mode;
        ball_r    <= (in_object_group == GROUP_BALL);
        time_r    <= in_sample_time;
        x_r       <= in_pos_x;
        y_r       <= in_pos_y;
        h_r       <= 16'(in_heading);
        obj_r     <= obj_in;
        base_r    <= AW'(32'(obj_in) * 32'(HISTORY_DEPTH));
        res_vld_r <= 1'b0;
        res_x_r   <= '0;
        res_y_r   <= '0;
        res_h_r   <= '0;
        res_ent_r <= '0;
      end
      S_LOAD: begin
        if (mode_r == MODE_APPEND) begin
          ptr_r <= ld_full ? wrap_inc(ld_ptr) : ld_ptr;
          cnt_r <= ld_full ? ld_cnt : ld_cnt + 1'b1;
          now_r <= time_r;
        end else begin
          ptr_r <= ld_ptr;
          cnt_r <= ld_cnt;
          now_r <= ball_r ? time_r : latest_r;
        end
      end
      S_PRUNE_CHK: if (drop) begin
        ptr_r <= ptr_inc;
        cnt_r <= cnt_r - 1'b1;
      end
      S_FIN:    res_ent_r <= 7'(cnt_r);
      S_RD_NEW: old_r <= hist_rd_r;  // oldest entry, read in S_FIN
      S_CALC: begin
        dt_r     <= hist_rd_r[79:48] - old_r[79:48];
        mag_r[0] <= mag16(dx);
        mag_r[1] <= mag16(dy);
        mag_r[2] <= ball_r ? '0 : mag16(dhw);
        neg_r    <= {dhw[16] && !ball_r, dy[16], dx[16]};
      end
      S_DIV: if (div_done) begin
        res_vld_r <= 1'b1;
        res_x_r   <= sat_vel(neg_r[0], quo[0]);
        res_y_r   <= sat_vel(neg_r[1], quo[1]);
        res_h_r   <= sat_vel(neg_r[2], quo[2]);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r        <= 1'b1;
        out_velocity_valid <= res_vld_r;
        out_vel_x          <= res_x_r;
        out_vel_y          <= res_y_r;
        out_vel_heading    <= res_h_r;
        out_entries_held   <= res_ent_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end
  assign out_valid = out_valid_r;

  // checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result dropped while stalled");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRUNE_RD |-> 32'(cnt_r) <= HISTORY_DEPTH)
    else $error("entry count above depth");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_velocity_valid |-> out_vel_x == '0 && out_vel_y == '0 &&
      out_vel_heading == '0)
    else $error("invalid result carries velocity");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second item taken before result");

endmodule

[tb/wve_checker.sv]
// Scoreboard for the windowed velocity estimator: watches the input, config and
// result channels, keeps its own copy of the pose histories and compares results.
// Depends on wve_pkg for the heading constants, the group and mode codes and the reset window.
module wve_checker #(
  parameter int HISTORY_DEPTH   = 64,
  parameter int ROBOTS_PER_TEAM = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_mode,
  input  logic [1:0]         in_object_group,
  input  logic [3:0]         in_robot_index,
  input  logic [31:0]        in_sample_time,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [14:0] in_heading,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_velocity_valid,
  input  logic signed [23:0] out_vel_x,
  input  logic signed [23:0] out_vel_y,
  input  logic signed [23:0] out_vel_heading,
  input  logic [6:0]         out_entries_held,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_window_length,
  output int                 fail_count,
  output int                 pending
);
  import wve_pkg::*;

  localparam int NOBJ = 2 * ROBOTS_PER_TEAM + 1;

  typedef struct packed {
    logic               valid;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vh;
    logic [6:0]         held;
  } velocity_t;

  velocity_t   velocity_q[$];
  logic [31:0] win;
  logic [31:0] hist_t[NOBJ][HISTORY_DEPTH];
  logic signed [15:0] hist_x[NOBJ][HISTORY_DEPTH];
  logic signed [15:0] hist_y[NOBJ][HISTORY_DEPTH];
  logic signed [15:0] hist_h[NOBJ][HISTORY_DEPTH];
  int          oldest[NOBJ];
  int          count[NOBJ];
  logic [31:0] robot_now;

  // rounded, saturated diff * 1e6 / dt
  function automatic logic signed [23:0] rate(input longint diff, input logic [31:0] dt);
    longint unsigned mag, q;
    mag = (diff < 0 ? -diff : diff) * 64'd1000000;
    q = (mag + (dt >> 1)) / dt;
    if (diff >= 0) return (q > 64'd8388607) ? 24'sh7FFFFF : 24'(q);
    return (q > 64'd8388608) ? 24'sh800000 : 24'(-longint'(q));
  endfunction

  function automatic velocity_t estimate(input logic mode, input logic [1:0] grp,
                                         input logic [3:0] idx, input logic [31:0] t,
                                         input logic signed [15:0] x,
                                         input logic signed [15:0] y,
                                         input logic signed [14:0] h);
    velocity_t r;
    int obj, slot, oi, ni;
    logic [31:0] now, t0, t1;
    longint dh;
    r = '0;
    if (grp == GROUP_NONE || (grp != GROUP_BALL && idx >= ROBOTS_PER_TEAM)) return r;
    obj = (grp == GROUP_BALL) ? 2 * ROBOTS_PER_TEAM : grp * ROBOTS_PER_TEAM + idx;
    if (mode == MODE_APPEND) begin
      if (count[obj] >= HISTORY_DEPTH) begin
        slot = oldest[obj];
        oldest[obj] = (oldest[obj] + 1) % HISTORY_DEPTH;
      end else begin
        slot = (oldest[obj] + count[obj]) % HISTORY_DEPTH;
        count[obj]++;
      end
      hist_t[obj][slot] = t;
      hist_x[obj][slot] = x;
      hist_y[obj][slot] = y;
      hist_h[obj][slot] = 16'(h);
      if (grp != GROUP_BALL) robot_now = t;
    end
    now = (grp == GROUP_BALL) ? t : robot_now;
    // drop stale entries from the oldest end
    while (count[obj] > 0) begin
      t0 = hist_t[obj][oldest[obj]];
      if (now > t0 && now - t0 > win) begin
        oldest[obj] = (oldest[obj] + 1) % HISTORY_DEPTH;
        count[obj]--;
      end else break;
    end
    r.held = 7'(count[obj]);
    if (count[obj] >= 2) begin
      oi = oldest[obj];
      ni = (oldest[obj] + count[obj] - 1) % HISTORY_DEPTH;
      t0 = hist_t[obj][oi];
      t1 = hist_t[obj][ni];
      if (t1 > t0) begin
        r.valid = 1'b1;
        r.vx = rate(longint'(hist_x[obj][ni]) - hist_x[obj][oi], t1 - t0);
        r.vy = rate(longint'(hist_y[obj][ni]) - hist_y[obj][oi], t1 - t0);
        if (grp != GROUP_BALL) begin
          dh = longint'(hist_h[obj][ni]) - hist_h[obj][oi];
          while (dh >= HEADING_PI) dh -= HEADING_TWO_PI;
          while (dh < -HEADING_PI) dh += HEADING_TWO_PI;
          r.vh = rate(dh, t1 - t0);
        end
      end
    end
    return r;
  endfunction

  assign pending = velocity_q.size();

  always @(posedge clk) begin
    velocity_t e, a;
    if (!rst_n) begin
      win <= WINDOW_RESET;
      robot_now = '0;
      for (int i = 0; i < NOBJ; i++) begin
        oldest[i] = 0;
        count[i] = 0;
      end
      velocity_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) win <= cfg_window_length;
      if (in_valid && in_ready)
        velocity_q = {velocity_q, estimate(in_mode, in_object_group, in_robot_index,
                                           in_sample_time, in_pos_x, in_pos_y,
                                           in_heading)};
      if (out_valid && out_ready) begin
        a = '{out_velocity_valid, out_vel_x, out_vel_y, out_vel_heading, out_entries_held};
        if (velocity_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = velocity_q.pop_front();
          if (e !== a) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb_windowed_velocity_estimator.sv]
// Top of the windowed velocity estimator testbench: clock, reset, stimulus and verdict.
// Depends on wve_pkg, the block and the wve_checker scoreboard.
module tb_windowed_velocity_estimator;
  import wve_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready, in_mode = 0;
  logic [1:0] in_object_group = 0;
  logic [3:0] in_robot_index = 0;
  logic [31:0] in_sample_time = 0;
  logic signed [15:0] in_pos_x = 0, in_pos_y = 0;
  logic signed [14:0] in_heading = 0;
  logic out_valid, out_ready = 0, out_velocity_valid;
  logic signed [23:0] out_vel_x, out_vel_y, out_vel_heading;
  logic [6:0] out_entries_held;
  logic cfg_valid = 0, cfg_ready;
  logic [31:0] cfg_window_length = 0;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;
  longint cycles = 0;
  logic [31:0] clock_us = 0;

  always #5 clk = ~clk;

  windowed_velocity_estimator dut (.*);
  wve_checker chk (.*);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_windowed_velocity_estimator: FAIL");
      $finish;
    end
  end

  // receiver with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send(input logic m, input logic [1:0] g, input logic [3:0] i,
                      input logic [31:0] t, input logic signed [15:0] x,
                      input logic signed [15:0] y, input logic signed [14:0] h);
    // valid drops low between items
    @(posedge clk);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1; in_mode <= m; in_object_group <= g; in_robot_index <= i;
    in_sample_time <= t; in_pos_x <= x; in_pos_y <= y; in_heading <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 0;
  endtask

  // wait until drained, then let the sequencer settle before a config write
  task automatic write_window(input logic [31:0] w);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1; cfg_window_length <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // random item: mostly well-formed, monotonic per object, small time steps
  task automatic random_item();
    logic [1:0] g;
    logic [3:0] i;
    logic [31:0] t;
    int r;
    r = $urandom_range(99);
    g = (r < 3) ? GROUP_NONE : 2'($urandom_range(2));
    i = 4'($urandom);
    if (r < 85) begin
      clock_us = clock_us + $urandom_range(40000);
      t = clock_us;
    end else if (r < 92) t = $urandom;
    else t = clock_us - $urandom_range(1000);
    send(1'($urandom_range(99) < 20), g, i, t, 16'($urandom), 16'($urandom),
         15'($urandom_range(25736)) - 15'sd12868);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, both modes, every group, bad objects, wrap, zero span
    send(MODE_APPEND, 2'd0, 4'd0, 32'd1000, 16'sh7FFF, 16'sh8000, 15'sd12868);
    send(MODE_APPEND, 2'd0, 4'd0, 32'd1001, 16'sh8000, 16'sh7FFF, -15'sd12868);
    send(MODE_APPEND, 2'd0, 4'd0, 32'd1001, 16'sd5, 16'sd5, 15'sd0);
    send(1'b1, 2'd0, 4'd0, 32'd0, 0, 0, 0);
    send(MODE_APPEND, 2'd1, 4'd15, 32'd2000, -16'sd100, 16'sd100, -15'sd12868);
    send(MODE_APPEND, 2'd1, 4'd15, 32'd3000, 16'sd100, -16'sd100, 15'sd12867);
    send(MODE_APPEND, GROUP_BALL, 4'd7, 32'd3000, 16'sd1, 16'sd1, 15'sd100);
    send(MODE_APPEND, GROUP_BALL, 4'd3, 32'd3003, 16'sd2, 16'sd3, 15'sd200);
    send(1'b1, GROUP_BALL, 4'd0, 32'd600000, 0, 0, 0);
    send(MODE_APPEND, GROUP_NONE, 4'd0, 32'hFFFFFFFF, 16'sh7FFF, 16'sh7FFF, 15'sd1);
    send(1'b1, GROUP_NONE, 4'hF, 32'd0, 0, 0, 0);
    send(MODE_APPEND, 2'd0, 4'd1, 32'hFFFFFFF0, 16'sd9, 16'sd9, 15'sd9);
    send(MODE_APPEND, 2'd0, 4'd1, 32'hFFFFFFFF, -16'sd9, -16'sd9, -15'sd9);
    send(1'b1, 2'd1, 4'd15, 32'd0, 0, 0, 0);
    write_window(32'd0);
    send(MODE_APPEND, GROUP_BALL, 4'd0, 32'd5000, 16'sd1, 16'sd1, 0);
    send(MODE_APPEND, GROUP_BALL, 4'd0, 32'd5000, 16'sd2, 16'sd1, 0);
    write_window(32'hFFFFFFFF);
    clock_us = 32'd10000;
    // history wraparound on one object
    for (int k = 0; k < 70; k++)
      send(MODE_APPEND, 2'd0, 4'd2, 32'd10000 + k, 16'(k * 7), 16'(-k), 15'(k * 300));
    // random phases at several windows and idling profiles
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 32; recv_idle = 67; write_window(32'd500000); end
        1: begin send_idle = 67; recv_idle = 32; write_window(32'd60000); end
        2: begin send_idle = 0; recv_idle = 0; write_window(32'd2000000); end
        default: begin write_window(32'd0); end
      endcase
      if (ph == 2) begin
        hold_off = 1;
        fork
          begin repeat (400) @(posedge clk); hold_off = 0; end
          for (int k = 0; k < 20; k++) random_item();
        join
      end
      for (int k = 0; k < 175; k++) random_item();
      if (ph == 1) while (pending != 0) @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("tb_windowed_velocity_estimator: PASS");
    else $display("tb_windowed_velocity_estimator: FAIL");
    $finish;
  end
endmodule
